/* hw/rtl/skeleton_pixel_classifier_defines.svh */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SKELETON_PIXEL_CLASSIFIER_DEFINES_SVH
`define SKELETON_PIXEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/spc_pkg.sv */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier package
// Types, register codes, label codes and reset values shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 13;
  localparam int LS_DATA_W     = 16;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FOREGROUND   = 2'd2
  } cfg_index_t;

  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [7:0]  FOREGROUND_RST   = 8'd255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    LBL_BLANK    = 3'd0,
    LBL_NORMAL   = 3'd1,
    LBL_ENDPOINT = 3'd2,
    LBL_JUNCTION = 3'd3,
    LBL_DOT      = 3'd4
  } label_t;

  // [row][col][bit], row 0 is the oldest line, col 0 the leftmost
  typedef logic [2:0][2:0][7:0] win_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [7:0]  foreground;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        top_ok;
    logic        bot_ok;
    logic        left_ok;
    logic        right_ok;
    logic        frame_end;
    logic [9:0]  col;
    logic [11:0] row;
  } meta_t;

endpackage

`default_nettype wire

/* hw/rtl/spc_line_store.sv */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier line store
// Both line stores side by side in one memory, registered read with
// write-to-read forwarding for a read of the address written that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_line_store #(
  parameter  int DEPTH = spc_pkg::MAX_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic [spc_pkg::LS_DATA_W-1:0]    wr_data,
  input  wire logic [AW-1:0]                    rd_addr,
  output      logic [spc_pkg::LS_DATA_W-1:0]    rd_data
);

  logic [spc_pkg::LS_DATA_W-1:0] mem [DEPTH];
  logic [spc_pkg::LS_DATA_W-1:0] rd_q_r;
  logic [spc_pkg::LS_DATA_W-1:0] fwd_data_r;
  logic                          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

`default_nettype wire

/* hw/rtl/spc_scan.sv */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier scan stage
// Input position, line stores and 3x3 window; works out the centre position
// and its image-edge flags and holds them with the window for the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_scan #(
  parameter int MAX_WIDTH = spc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spc_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire logic           in_op,
  input  wire logic [7:0]     in_pixel,
  input  wire logic           take,
  output      spc_pkg::win_t  win,
  output      spc_pkg::meta_t meta
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = spc_pkg::ROW_W;

  logic [WW-1:0]                 w;
  logic [RW-1:0]                 h;
  logic [CW-1:0]                 in_col_r, in_col_nxt;
  logic [RW-1:0]                 in_row_r, in_row_nxt;
  spc_pkg::win_t                 win_r, win_nxt;
  spc_pkg::meta_t                meta_r, meta_nxt;
  logic [spc_pkg::LS_DATA_W-1:0] ls_rd;
  logic [spc_pkg::LS_DATA_W-1:0] ls_wr;
  logic                          accept, skip, step;
  logic [7:0]                    px;
  logic                          c_first, row_ok, has_res;
  logic [RW-1:0]                 crow;
  logic [CW-1:0]                 ccol;
  logic                          top_ok, bot_ok, left_ok, right_ok, fe;
  logic [CW:0]                   col_inc;
  logic [CW-1:0]                 col_step;
  logic [RW-1:0]                 row_step;
  logic                          restart;

  // effective frame size
  always_comb begin
    if (cfg.image_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = RW'(1);
    end else if (32'(cfg.image_height) > 32'(spc_pkg::MAX_HEIGHT)) begin
      h = RW'(spc_pkg::MAX_HEIGHT);
    end else begin
      h = cfg.image_height;
    end
  end

  assign in_stall = meta_r.valid && !take;
  assign accept   = in_valid && !in_stall;
  assign skip     = (in_op == spc_pkg::OP_FLUSH) && (in_col_r == '0) && (in_row_r == '0);
  assign step     = accept && !skip;
  assign px       = ((in_op == spc_pkg::OP_FLUSH) || (in_row_r >= h)) ? 8'd0 : in_pixel;
  assign ls_wr    = {ls_rd[7:0], px};

  // centre lags the input by one line and one pixel
  always_comb begin
    c_first  = (in_col_r == '0);
    row_ok   = c_first ? (in_row_r >= RW'(2)) : (in_row_r != '0);
    crow     = in_row_r - (c_first ? RW'(2) : RW'(1));
    ccol     = c_first ? CW'(w - WW'(1)) : (in_col_r - CW'(1));
    has_res  = row_ok && (crow < h) && (WW'(ccol) < w);
    top_ok   = (crow != '0);
    bot_ok   = (crow != (h - RW'(1)));
    left_ok  = (ccol != '0);
    right_ok = (WW'(ccol) != (w - WW'(1)));
    fe       = !bot_ok && !right_ok;
  end

  always_comb begin
    col_inc = (CW + 1)'(in_col_r) + (CW + 1)'(1);
    if (col_inc >= (CW + 1)'(w)) begin
      col_step = '0;
      row_step = in_row_r + RW'(1);
    end else begin
      col_step = col_inc[CW-1:0];
      row_step = in_row_r;
    end
    restart = (has_res && fe) ||
              ((RW + 1)'(row_step) >= ((RW + 1)'(h) + (RW + 1)'(2)));
    if (step) begin
      in_col_nxt = restart ? '0 : col_step;
      in_row_nxt = restart ? '0 : row_step;
    end else begin
      in_col_nxt = in_col_r;
      in_row_nxt = in_row_r;
    end
  end

  always_comb begin
    win_nxt = win_r;
    if (step) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
      end
      win_nxt[0][2] = ls_rd[15:8];
      win_nxt[1][2] = ls_rd[7:0];
      win_nxt[2][2] = px;
    end
  end

  always_comb begin
    meta_nxt = meta_r;
    if (accept) begin
      meta_nxt.valid     = step && has_res;
      meta_nxt.top_ok    = top_ok;
      meta_nxt.bot_ok    = bot_ok;
      meta_nxt.left_ok   = left_ok;
      meta_nxt.right_ok  = right_ok;
      meta_nxt.frame_end = fe;
      meta_nxt.col       = 10'(ccol);
      meta_nxt.row       = crow[11:0];
    end else if (take) begin
      meta_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r     <= '0;
      in_row_r     <= '0;
      win_r        <= '0;
      meta_r.valid <= 1'b0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      win_r    <= win_nxt;
      meta_r   <= meta_nxt;
    end
  end

  spc_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (step),
    .wr_addr (in_col_r),
    .wr_data (ls_wr),
    .rd_addr (in_col_nxt),
    .rd_data (ls_rd)
  );

  assign win  = win_r;
  assign meta = meta_r;

endmodule

`default_nettype wire

/* hw/rtl/spc_classify.sv */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier label stage
// Counts foreground pixels in the window inside the image and registers the
// label word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "skeleton_pixel_classifier_defines.svh"

module spc_classify (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     foreground,
  input  wire spc_pkg::win_t  win,
  input  wire spc_pkg::meta_t meta,
  output      logic           take,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic [2:0]     out_label,
  output      logic [9:0]     out_col,
  output      logic [11:0]    out_row,
  output      logic           out_frame_end
);

  logic             out_valid_r;
  spc_pkg::label_t  label_r, label_nxt;
  logic [9:0]       col_r;
  logic [11:0]      row_r;
  logic             fe_r;
  logic [2:0]       row_msk, col_msk;
  logic [3:0]       count;

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    row_msk = {meta.bot_ok, 1'b1, meta.top_ok};
    col_msk = {meta.right_ok, 1'b1, meta.left_ok};
    count   = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        count = count + 4'(row_msk[i] && col_msk[j] && (win[i][j] == foreground));
      end
    end
    if (win[1][1] == 8'd0) begin
      label_nxt = spc_pkg::LBL_BLANK;
    end else if (count == 4'd3) begin
      label_nxt = spc_pkg::LBL_NORMAL;
    end else if (count == 4'd2) begin
      label_nxt = spc_pkg::LBL_ENDPOINT;
    end else if (count > 4'd3) begin
      label_nxt = spc_pkg::LBL_JUNCTION;
    end else begin
      label_nxt = spc_pkg::LBL_DOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && meta.valid) begin
      label_r <= label_nxt;
      col_r   <= meta.col;
      row_r   <= meta.row;
      fe_r    <= meta.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_label     = label_r;
  assign out_col       = col_r;
  assign out_row       = row_r;
  assign out_frame_end = fe_r;

  `SPC_ASSERT_NEXT(a_blank_centre, take && meta.valid && (win[1][1] == 8'd0), out_label == spc_pkg::LBL_BLANK, "zero centre not labelled blank")
  `SPC_ASSERT_NEXT(a_single_column, take && meta.valid && !meta.left_ok && !meta.right_ok, out_label != spc_pkg::LBL_JUNCTION, "junction in a one-pixel-wide frame")
  `SPC_ASSERT_NEXT(a_lone_pixel, take && meta.valid && !meta.left_ok && !meta.right_ok && !meta.top_ok && !meta.bot_ok, (out_label == spc_pkg::LBL_BLANK) || (out_label == spc_pkg::LBL_DOT), "single-pixel frame not blank or dot")

endmodule

`default_nettype wire

/* hw/rtl/skeleton_pixel_classifier.sv */
// ----------------------------------------------------------------------------
// Skeleton pixel classifier
// Labels each pixel of a thinned skeleton as blank, normal, endpoint,
// junction or isolated dot from its 3x3 neighbourhood.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per pixel in raster order (in_op pixel), then flush
//           words (in_op flush); image_width+1 flushes label the last pixel.
//   out_* : one label word per centre pixel, with its column and row;
//           out_frame_end marks the frame's last pixel.
//   cfg_* : register writes; the user writes only while no word is in flight, the block does not enforce it.
//   A word is taken on an edge with valid high and stall low.
//   Throughput: one word per clock unless stalled; one line store read and
//   one write a clock, the read for the next column issued as a word is taken.
//   Label path: the word that completes a pixel's window comes image_width+1
//   words after the pixel; the scan stage holds the window, then out_* the label.
//   Reset: position and window cleared, registers to 640 x 480, foreground
//   255; the line stores are not cleared and need no clearing pass.
//   Output stall: one label waits in the output register and one more in
//   the scan stage; in_stall rises only when both are held.
// ----------------------------------------------------------------------------
`default_nettype none

module skeleton_pixel_classifier #(
  parameter int MAX_WIDTH = spc_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             in_op,
  input  wire logic [7:0]                       in_pixel,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [2:0]                       out_label,
  output      logic [9:0]                       out_col,
  output      logic [11:0]                      out_row,
  output      logic                             out_frame_end,
  input  wire logic                             cfg_we,
  input  wire logic [spc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  spc_pkg::cfg_t  cfg_r;
  spc_pkg::win_t  win;
  spc_pkg::meta_t meta;
  logic           take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= spc_pkg::IMAGE_WIDTH_RST;
      cfg_r.image_height <= spc_pkg::IMAGE_HEIGHT_RST;
      cfg_r.foreground   <= spc_pkg::FOREGROUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spc_pkg::CFG_IMAGE_WIDTH: begin
          cfg_r.image_width <= cfg_data[10:0];
        end
        spc_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_r.image_height <= cfg_data[12:0];
        end
        spc_pkg::CFG_FOREGROUND: begin
          cfg_r.foreground <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  spc_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_pixel (in_pixel),
    .take     (take),
    .win      (win),
    .meta     (meta)
  );

  spc_classify u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .foreground    (cfg_r.foreground),
    .win           (win),
    .meta          (meta),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_label     (out_label),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

/* sim/tb_skeleton_pixel_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Skeleton pixel classifier testbench
// Streams skeleton frames through the classifier and checks every label word
// against a behavioural predictor of the line stores and 3x3 window. A short
// table of hand-labelled frames comes first, then random frames over a range
// of image sizes and foreground values, zero sizes among them, with random
// valid gaps and output stalls.
// ----------------------------------------------------------------------------

module tb_skeleton_pixel_classifier;

  localparam int LINE_LEN    = spc_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 16;
  localparam int QUIET_LIMIT = 500;
  localparam int RAND_WORDS  = 1250;

  typedef struct packed {
    spc_pkg::label_t label;
    logic [9:0]      col;
    logic [11:0]     row;
    logic            frame_end;
  } label_word_t;

  typedef struct packed {
    logic                even_pad_unused_is_reg;
    spc_pkg::cfg_index_t idx;
    logic [12:0]         data;
    logic                op;
    logic [7:0]          pix;
    logic                typed;
    spc_pkg::label_t     lbl;
  } tab_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_op;
  logic [7:0]                      in_pixel;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [2:0]                      out_label;
  logic [9:0]                      out_col;
  logic [11:0]                     out_row;
  logic                            out_frame_end;
  logic                            cfg_we;
  logic [spc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data;

  bit          idle_on = 1'b1;
  int          stall_left;
  int          quiet_cycles;
  int          mismatch_cnt;
  int          words_sent;
  label_word_t pending_labels[$];
  tab_row_t    word_table[$];

  // predictor state
  logic [10:0] reg_w;
  logic [12:0] reg_h;
  logic [7:0]  reg_fg;
  logic [7:0]  store_a[LINE_LEN];
  logic [7:0]  store_b[LINE_LEN];
  logic [7:0]  win[3][3];
  int          pos_col;
  int          pos_row;

  skeleton_pixel_classifier uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_label    (out_label),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_frame_end(out_frame_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // label of the centre pixel completed by one accepted word, if any
  function automatic bit label_of_word(input logic op, input logic [7:0] pix,
                                       output label_word_t res);
    int w, h, c, ccol, crow, hits, r, cc;
    logic [7:0] p;
    w = (reg_w == 0) ? 1 : ((reg_w > LINE_LEN) ? LINE_LEN : int'(reg_w));
    h = (reg_h == 0) ? 1 : ((reg_h > spc_pkg::MAX_HEIGHT) ? spc_pkg::MAX_HEIGHT : int'(reg_h));
    res = '0;
    if (op == spc_pkg::OP_FLUSH && pos_col == 0 && pos_row == 0) return 1'b0;
    p = (op == spc_pkg::OP_FLUSH || pos_row >= h) ? 8'd0 : pix;
    c = (pos_col >= LINE_LEN) ? 0 : pos_col;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = store_b[c];
    win[1][2] = store_a[c];
    win[2][2] = p;
    store_b[c] = store_a[c];
    store_a[c] = p;
    if (c == 0) begin
      ccol = w - 1;
      crow = pos_row - 2;
    end else begin
      ccol = c - 1;
      crow = pos_row - 1;
    end
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 'h1FFF;
    end
    if (crow < 0 || crow >= h || ccol >= w) begin
      if (pos_row >= h + 2) begin
        pos_col = 0;
        pos_row = 0;
      end
      return 1'b0;
    end
    hits = 0;
    for (int i = 0; i < 3; i++) begin
      r = crow - 1 + i;
      for (int j = 0; j < 3; j++) begin
        cc = ccol - 1 + j;
        if (r >= 0 && r < h && cc >= 0 && cc < w && win[i][j] == reg_fg) hits++;
      end
    end
    if (win[1][1] == 8'd0) res.label = spc_pkg::LBL_BLANK;
    else if (hits == 3) res.label = spc_pkg::LBL_NORMAL;
    else if (hits == 2) res.label = spc_pkg::LBL_ENDPOINT;
    else if (hits > 3) res.label = spc_pkg::LBL_JUNCTION;
    else res.label = spc_pkg::LBL_DOT;
    res.col = ccol[9:0];
    res.row = crow[11:0];
    res.frame_end = (crow == h - 1 && ccol == w - 1);
    if (res.frame_end || pos_row >= h + 2) begin
      pos_col = 0;
      pos_row = 0;
    end
    return 1'b1;
  endfunction

  task automatic send_word(input logic op, input logic [7:0] pix, input bit typed = 1'b0,
                           input spc_pkg::label_t typed_lbl = spc_pkg::LBL_BLANK);
    label_word_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (label_of_word(op, pix, res)) begin
      if (typed) res.label = typed_lbl;
      pending_labels.push_back(res);
    end
  endtask

  // registers change only once every label is out and the pipe has emptied
  task automatic write_reg(input spc_pkg::cfg_index_t idx, input int unsigned val);
    in_valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[spc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      spc_pkg::CFG_IMAGE_WIDTH:  reg_w  = val[10:0];
      spc_pkg::CFG_IMAGE_HEIGHT: reg_h  = val[12:0];
      spc_pkg::CFG_FOREGROUND:   reg_fg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned w, input int unsigned h, input int unsigned fg);
    write_reg(spc_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(spc_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(spc_pkg::CFG_FOREGROUND, fg);
  endtask

  function automatic logic [7:0] skeleton_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return reg_fg;
    if (pick < 75) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // whole frames only, so every phase ends with the position back at zero
  task automatic send_frames(input int n_frames);
    int w, h;
    w = (reg_w == 0) ? 1 : ((reg_w > LINE_LEN) ? LINE_LEN : int'(reg_w));
    h = (reg_h == 0) ? 1 : ((reg_h > spc_pkg::MAX_HEIGHT) ? spc_pkg::MAX_HEIGHT : int'(reg_h));
    repeat (n_frames) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 2))
          send_word(spc_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
      send_word(spc_pkg::OP_PIXEL, skeleton_pixel());
      for (int i = 1; i < w * h; i++)
        send_word(($urandom_range(0, 19) == 0) ? spc_pkg::OP_FLUSH : spc_pkg::OP_PIXEL,
                  skeleton_pixel());
      for (int i = 0; i <= w; i++)
        send_word(($urandom_range(0, 4) == 0) ? spc_pkg::OP_PIXEL : spc_pkg::OP_FLUSH,
                  8'($urandom_range(0, 255)));
    end
  endtask

  task automatic tab_reg(input spc_pkg::cfg_index_t idx, input int unsigned val);
    tab_row_t row;
    row = '0;
    row.even_pad_unused_is_reg = 1'b1;
    row.idx = idx;
    row.data = val[12:0];
    word_table.push_back(row);
  endtask

  task automatic tab_word(input logic op, input logic [7:0] pix, input bit typed = 1'b0,
                          input spc_pkg::label_t lbl = spc_pkg::LBL_BLANK);
    tab_row_t row;
    row = '0;
    row.op = op;
    row.pix = pix;
    row.typed = typed;
    row.lbl = lbl;
    word_table.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_labels
    label_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_labels.size() == 0) begin
        note_mismatch($sformatf("label word with none pending, col %0d row %0d",
                                out_col, out_row));
      end else begin
        want = pending_labels.pop_front();
        if (out_label !== want.label)
          note_mismatch($sformatf("label %0d, want %0d at col %0d row %0d",
                                  out_label, want.label, want.col, want.row));
        if (out_col !== want.col)
          note_mismatch($sformatf("col %0d, want %0d", out_col, want.col));
        if (out_row !== want.row)
          note_mismatch($sformatf("row %0d, want %0d", out_row, want.row));
        if (out_frame_end !== want.frame_end)
          note_mismatch($sformatf("frame_end %0b, want %0b at col %0d row %0d",
                                  out_frame_end, want.frame_end, want.col, want.row));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int base;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_op     <= spc_pkg::OP_PIXEL;
    in_pixel  <= 8'd0;
    cfg_we    <= 1'b0;
    cfg_index <= spc_pkg::CFG_IMAGE_WIDTH;
    cfg_data  <= '0;
    reg_w  = spc_pkg::IMAGE_WIDTH_RST;
    reg_h  = spc_pkg::IMAGE_HEIGHT_RST;
    reg_fg = spc_pkg::FOREGROUND_RST;
    for (int i = 0; i < LINE_LEN; i++) begin
      store_a[i] = 8'd0;
      store_b[i] = 8'd0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
    pos_col = 0;
    pos_row = 0;

    // 3x3 frame: leading flush dropped, flush inside, pixel after the last one
    tab_reg(spc_pkg::CFG_IMAGE_WIDTH, 3);
    tab_reg(spc_pkg::CFG_IMAGE_HEIGHT, 3);
    tab_reg(spc_pkg::CFG_FOREGROUND, 255);
    tab_word(spc_pkg::OP_FLUSH, 8'd255);
    tab_word(spc_pkg::OP_PIXEL, 8'd255);
    tab_word(spc_pkg::OP_PIXEL, 8'd255);
    tab_word(spc_pkg::OP_PIXEL, 8'd255);
    tab_word(spc_pkg::OP_PIXEL, 8'd0);
    tab_word(spc_pkg::OP_PIXEL, 8'd255, 1'b1, spc_pkg::LBL_NORMAL);
    tab_word(spc_pkg::OP_PIXEL, 8'd7,   1'b1, spc_pkg::LBL_JUNCTION);
    tab_word(spc_pkg::OP_PIXEL, 8'd255, 1'b1, spc_pkg::LBL_NORMAL);
    tab_word(spc_pkg::OP_FLUSH, 8'd0,   1'b1, spc_pkg::LBL_BLANK);
    tab_word(spc_pkg::OP_PIXEL, 8'd9,   1'b1, spc_pkg::LBL_JUNCTION);
    tab_word(spc_pkg::OP_PIXEL, 8'd255, 1'b1, spc_pkg::LBL_NORMAL);
    tab_word(spc_pkg::OP_FLUSH, 8'd0,   1'b1, spc_pkg::LBL_ENDPOINT);
    tab_word(spc_pkg::OP_FLUSH, 8'd0,   1'b1, spc_pkg::LBL_BLANK);
    tab_word(spc_pkg::OP_FLUSH, 8'd0,   1'b1, spc_pkg::LBL_DOT);
    // one column, zero foreground: zero centre stays blank
    tab_reg(spc_pkg::CFG_IMAGE_WIDTH, 1);
    tab_reg(spc_pkg::CFG_IMAGE_HEIGHT, 2);
    tab_reg(spc_pkg::CFG_FOREGROUND, 0);
    tab_word(spc_pkg::OP_PIXEL, 8'd0);
    tab_word(spc_pkg::OP_PIXEL, 8'd5);
    tab_word(spc_pkg::OP_FLUSH, 8'd0, 1'b1, spc_pkg::LBL_BLANK);
    tab_word(spc_pkg::OP_FLUSH, 8'd0, 1'b1, spc_pkg::LBL_DOT);
    tab_reg(spc_pkg::CFG_IMAGE_WIDTH, 2);
    tab_reg(spc_pkg::CFG_IMAGE_HEIGHT, 1);
    tab_reg(spc_pkg::CFG_FOREGROUND, 128);
    tab_word(spc_pkg::OP_PIXEL, 8'd128);
    tab_word(spc_pkg::OP_PIXEL, 8'd127);
    tab_word(spc_pkg::OP_FLUSH, 8'd1);
    tab_word(spc_pkg::OP_FLUSH, 8'd0);
    tab_word(spc_pkg::OP_FLUSH, 8'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (word_table[k]) begin
      if (word_table[k].even_pad_unused_is_reg)
        write_reg(word_table[k].idx, word_table[k].data);
      else
        send_word(word_table[k].op, word_table[k].pix, word_table[k].typed,
                  word_table[k].lbl);
    end

    set_regs(5, 4, 255);
    send_frames(3);
    set_regs(1, 1, 0);
    send_frames(20);
    set_regs(0, 0, $urandom_range(1, 254));
    send_frames(10);

    base = words_sent;
    while (words_sent - base < RAND_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       set_regs($urandom_range(1, 12), $urandom_range(1, 10), 255);
        1:       set_regs($urandom_range(1, 12), $urandom_range(1, 10), 0);
        default: set_regs($urandom_range(1, 12), $urandom_range(1, 10),
                          $urandom_range(0, 255));
      endcase
      send_frames($urandom_range(1, 3));
    end

    idle_on = 1'b0;
    set_regs(7, 5, 255);
    send_frames(4);

    in_valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_line_store.sv
hw/rtl/spc_scan.sv
hw/rtl/spc_classify.sv
hw/rtl/skeleton_pixel_classifier.sv
sim/tb_skeleton_pixel_classifier.sv
